[design/binary_search_divider_assert.svh]
// ----------------------------------------------------------------------------
// Binary search divider assertion macros
// Clocked, reset-qualified property wrappers used by the divider controller.
// ----------------------------------------------------------------------------
`ifndef BINARY_SEARCH_DIVIDER_ASSERT_SVH
`define BINARY_SEARCH_DIVIDER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bsd_pkg.sv]
// ----------------------------------------------------------------------------
// Binary search divider package
// Shared width constant, controller state type and datapath command struct.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Default operand and quotient width
  localparam int unsigned OperandBits = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PUSH
  } bsd_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture operands, clear remainder
    logic step;  // one quotient bit trial
    logic push;  // move finished result into the output register
  } bsd_cmd_t;

endpackage

[design/bsd_datapath.sv]
// ----------------------------------------------------------------------------
// Binary search divider datapath
// Operand registers, one trial subtract and compare per quotient bit, and the
// output register that holds a finished result until it is taken.
// ----------------------------------------------------------------------------
module bsd_datapath #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic                    clk_i,
  input  bsd_pkg::bsd_cmd_t       cmd_i,
  input  logic [OPERAND_BITS-1:0] numerator_i,
  input  logic [OPERAND_BITS-1:0] denominator_i,
  output logic [OPERAND_BITS-1:0] floor_quotient_o,
  output logic                    zero_divisor_o
);
  import bsd_pkg::*;

  localparam int unsigned OB = OPERAND_BITS;

  logic [OB-1:0] num_q, num_d;    // numerator kept for the zero divisor case
  logic [OB-1:0] den_q, den_d;
  logic [OB-1:0] shq_q, shq_d;    // numerator bits shift out, quotient bits in
  logic [OB-1:0] rem_q, rem_d;
  logic [OB-1:0] res_q, res_d;
  logic          zdiv_q, zdiv_d;
  logic [OB:0]   trial;
  logic [OB+1:0] diff;
  logic          fits;

  // Candidate bit set: accept it when the partial product stays within range
  assign trial = {rem_q, shq_q[OB-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign fits  = ~diff[OB+1];

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    shq_d  = shq_q;
    rem_d  = rem_q;
    res_d  = res_q;
    zdiv_d = zdiv_q;
    if (cmd_i.load) begin
      num_d = numerator_i;
      den_d = denominator_i;
      shq_d = numerator_i;
      rem_d = '0;
    end else if (cmd_i.step) begin
      shq_d = {shq_q[OB-2:0], fits};
      rem_d = fits ? diff[OB-1:0] : trial[OB-1:0];
    end
    if (cmd_i.push) begin
      zdiv_d = (den_q == '0);
      res_d  = (den_q == '0) ? num_q : shq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    shq_q  <= shq_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    zdiv_q <= zdiv_d;
  end

  assign floor_quotient_o = res_q;
  assign zero_divisor_o   = zdiv_q;

endmodule

[design/bsd_ctrl.sv]
// ----------------------------------------------------------------------------
// Binary search divider controller
// Sequences load, one trial per quotient bit and the result push, and owns
// both stream handshakes.
// ----------------------------------------------------------------------------
`include "binary_search_divider_assert.svh"

module bsd_ctrl #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bsd_pkg::bsd_cmd_t cmd_o
);
  import bsd_pkg::*;

  localparam int unsigned CntBits = $clog2(OPERAND_BITS);
  localparam logic [CntBits-1:0] CntTop = CntBits'(OPERAND_BITS - 1);

  bsd_state_e         state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               ovld_q, ovld_d;
  logic               out_free;

  assign out_free = ~ovld_q | out_ready_i;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovld_d     = ovld_q & ~out_ready_i;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CntTop;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // hold the result until the output register has room
        if (out_free) begin
          cmd_o.push = 1'b1;
          ovld_d     = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

  assign out_valid_o = ovld_q;

  `BSD_ASSERT_NEXT(a_load_starts_run, cmd_o.load,
                   state_q == ST_RUN && cnt_q == CntTop, "load did not start a full run")
  `BSD_ASSERT_NEXT(a_last_step_pushes, state_q == ST_RUN && cnt_q == '0,
                   state_q == ST_PUSH, "run did not end after the last bit")
  `BSD_ASSERT_NEXT(a_push_sets_valid, cmd_o.push, ovld_q, "pushed result not presented")
  `BSD_ASSERT_IMPL(a_no_push_over_held, cmd_o.push, !ovld_q || out_ready_i,
                   "result pushed over an untaken one")

endmodule

[design/binary_search_divider.sv]
// ----------------------------------------------------------------------------
// Binary search divider
// Unsigned floor division, one quotient bit decided per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: numerator and denominator packed in tdata. An item is
//   taken when tvalid and tready are both high; tready is high only while the
//   divider is idle, so one division is worked on at a time.
//   Output stream m_axis: floor quotient in tdata, zero divisor flag in tuser.
//   A zero denominator returns the numerator as quotient and sets the flag.
// Sequence:
//   The transfer edge loads the operands, one trial subtract and compare per
//   quotient bit follows, and a push moves the result into the output
//   register once that has room. The bit-serial trial loop sets the rate:
//   the next transfer waits for the idle state after the push, so a new item
//   is not taken before the last result has been pushed.
// Stalls:
//   The output register holds a finished result while m_axis_tready_i is low;
//   the next item is accepted and worked on meanwhile, and its result waits
//   in the datapath until the register frees.
// Reset:
//   rst_ni clears the controller and drops m_axis_tvalid_o; operand and
//   result registers are not reset.
// ----------------------------------------------------------------------------
module binary_search_divider #(
  parameter int unsigned OPERAND_BITS = bsd_pkg::OperandBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // numerator, denominator (from bit 0), zero padded to bytes
  input  logic [((2*OPERAND_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // floor_quotient (from bit 0), zero padded to bytes
  output logic [((OPERAND_BITS+7)/8)*8-1:0]      m_axis_tdata_o,
  // zero_divisor
  output logic                                   m_axis_tuser_o
);
  import bsd_pkg::*;

  localparam int unsigned OB       = OPERAND_BITS;
  localparam int unsigned OutBytes = ((OB + 7) / 8) * 8;

  bsd_cmd_t      cmd;
  logic [OB-1:0] quotient;

  bsd_ctrl #(
    .OPERAND_BITS(OB)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd)
  );

  bsd_datapath #(
    .OPERAND_BITS(OB)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .numerator_i     (s_axis_tdata_i[OB-1:0]),
    .denominator_i   (s_axis_tdata_i[2*OB-1:OB]),
    .floor_quotient_o(quotient),
    .zero_divisor_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OutBytes'(quotient);

endmodule

[sim/binary_search_divider_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary search divider testbench
// Streams numerator/denominator pairs into the divider under three mixes of
// sender and receiver back-pressure, predicts each floor quotient and zero
// divisor flag, and checks every returned transfer against the oldest
// prediction still pending.
// ----------------------------------------------------------------------------
module binary_search_divider_test;

  localparam int unsigned OpBits      = bsd_pkg::OperandBits;
  localparam int unsigned InDataBits  = ((2*OpBits+7)/8)*8;
  localparam int unsigned OutDataBits = ((OpBits+7)/8)*8;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReports  = 30;

  typedef logic [OpBits-1:0] operand_t;

  typedef struct {
    operand_t quotient;
    logic     zero_divisor;
  } quotient_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic [InDataBits-1:0]  s_data = '0;
  logic                   m_ready = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OutDataBits-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  quotient_t   pending_quotients[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  binary_search_divider DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d divisions pending",
               cycle_count, pending_quotients.size());
      $display("binary_search_divider_test NOT OK");
      $finish;
    end
  end

  // Floor quotient; a zero denominator hands back the numerator and flags it
  function automatic quotient_t predict_quotient(operand_t num, operand_t den);
    quotient_t q;
    q.zero_divisor = (den == '0);
    q.quotient     = q.zero_divisor ? num : num / den;
    return q;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got,
                                 longint unsigned want);
    if (mismatch_count < MaxReports)
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(negedge clk_i) begin
    m_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    quotient_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_quotients.size() == 0) begin
        report_mismatch("result transfer with no division pending",
                        m_axis_tdata_o, 0);
      end else begin
        want = pending_quotients.pop_front();
        if (m_axis_tdata_o[OpBits-1:0] !== want.quotient)
          report_mismatch("floor_quotient", m_axis_tdata_o[OpBits-1:0],
                          want.quotient);
        if (m_axis_tuser_o !== want.zero_divisor)
          report_mismatch("zero_divisor", m_axis_tuser_o, want.zero_divisor);
      end
    end
    if (rst_ni && s_valid && s_axis_tready_o)
      pending_quotients.push_back(predict_quotient(s_data[OpBits-1:0],
                                                   s_data[2*OpBits-1:OpBits]));
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_division(operand_t num, operand_t den);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(InDataBits-2*OpBits){1'b0}}, den, num};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the input until every pending result has come back
  task automatic wait_for_results();
    s_valid <= 1'b0;
    @(negedge clk_i);
    while (pending_quotients.size() != 0) @(negedge clk_i);
  endtask

  // Random value with a random number of leading zeros
  function automatic operand_t scaled_operand();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[OpBits-1:0] >> $urandom_range(OpBits-1, 0);
  endfunction

  task automatic test_directed_operands();
    operand_t top;
    top = '1;
    send_division('0, '0);
    send_division('0, operand_t'(1));
    send_division('0, top);
    send_division(top, '0);
    send_division(operand_t'(1), '0);
    send_division(operand_t'(12345), '0);
    send_division(top, operand_t'(1));
    send_division(top, top);
    send_division(top - operand_t'(1), top);
    send_division(operand_t'(1), top);
    send_division(top, operand_t'(2));
    send_division(top, operand_t'(3));
    send_division(operand_t'(1), operand_t'(1));
    send_division(operand_t'(100), operand_t'(10));
    send_division(operand_t'(101), operand_t'(10));
    send_division(operand_t'(99), operand_t'(10));
    send_division(operand_t'(7), operand_t'(3));
    send_division({1'b1, {(OpBits-1){1'b0}}}, operand_t'(1));
    send_division(top, {1'b1, {(OpBits-1){1'b0}}});
    send_division(operand_t'({(OpBits/2+1){2'b01}}),
                  operand_t'({(OpBits/2+1){2'b10}}));
    send_division(operand_t'({(OpBits/2+1){2'b10}}),
                  operand_t'({(OpBits/2+1){2'b01}}));
    send_division(operand_t'(46341) * operand_t'(46340), operand_t'(46341));
  endtask

  task automatic test_random_divisions(int unsigned count);
    operand_t num, den, q;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          num = scaled_operand();
          den = scaled_operand();
        end
        3: begin
          // exact multiple: the search can finish on an equal product
          den = scaled_operand();
          if (den == '0) den = operand_t'(1);
          q   = scaled_operand() / den;
          num = q * den;
        end
        4: begin
          num = scaled_operand();
          den = (num == '1) ? num : num + operand_t'(1) + (scaled_operand() >> 1);
          if (den < num) den = '1;
        end
        5: begin
          num = scaled_operand();
          den = '0;
        end
        6: begin
          num = scaled_operand();
          den = operand_t'($urandom_range(4, 1));
        end
        7: begin
          num = operand_t'({$urandom, $urandom});
          den = operand_t'({$urandom, $urandom});
        end
        8: begin
          num = '1 - operand_t'($urandom_range(7));
          den = scaled_operand();
        end
        default: begin
          num = operand_t'($urandom_range(3));
          den = scaled_operand();
        end
      endcase
      send_division(num, den);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 29;
    recv_idle_pct = 76;
    test_directed_operands();
    test_random_divisions(190);
    wait_for_results();

    send_idle_pct = 76;
    recv_idle_pct = 29;
    test_random_divisions(200);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_divisions(200);
    wait_for_results();

    // let any stray result show up
    repeat (OpBits + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_quotients.size() == 0) begin
      $display("binary_search_divider_test OK");
    end else begin
      $display("binary_search_divider_test NOT OK");
    end
    $finish;
  end

endmodule
